/* rtl/core/bbspi_pkg.sv */
// bbspi_pkg: types and constants shared by the bit-banged spi port
// request/response payloads, shift state, register bit positions
// no dependencies
package bbspi_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned CntW     = $clog2(ByteBits);

  // bit positions in the write data byte
  localparam int unsigned CsIdx   = 2;
  localparam int unsigned SendIdx = 4;
  localparam int unsigned DataIdx = 6;

  localparam logic [7:0] InOne   = 8'h04;
  localparam logic [7:0] Preload = 8'hFF;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] write_data;
    logic       card_has_byte;
    logic [7:0] card_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       card_byte_taken;
    logic       latch_valid;
    logic [7:0] latch_byte;
  } rsp_t;

  typedef struct packed {
    logic [7:0]      tx_shift;
    logic [CntW-1:0] tx_count;
    logic [7:0]      rx_shift;
    logic [CntW-1:0] rx_count;
    logic            rx_pending;
  } state_t;

endpackage

/* rtl/core/bbspi_if.sv */
// bbspi request and response channels: valid/ready handshake with payload
// depends on bbspi_pkg
interface bbspi_req_if import bbspi_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bbspi_rsp_if import bbspi_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/bbspi_step.sv */
// bbspi_step: next shift state and response for one bus access
// purely combinational; depends on bbspi_pkg
module bbspi_step import bbspi_pkg::*; (
  input  state_t state_i,
  input  req_t   req_i,
  output state_t state_o,
  output rsp_t   rsp_o
);

  logic [7:0]    rx_src;
  logic [CntW:0] rx_cnt;
  logic [7:0]    tx_next;
  logic [CntW:0] tx_cnt;

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    rx_src  = state_i.rx_pending ? state_i.rx_shift : req_i.card_byte;
    rx_cnt  = (state_i.rx_pending ? {1'b0, state_i.rx_count} : '0) + (CntW+1)'(1);
    tx_next = {state_i.tx_shift[6:0], ~req_i.write_data[DataIdx]};
    tx_cnt  = {1'b0, state_i.tx_count} + (CntW+1)'(1);

    case (req_i.op)
      OpRead: begin
        if (state_i.rx_pending || req_i.card_has_byte) begin
          rsp_o.card_byte_taken = !state_i.rx_pending;
          rsp_o.read_data       = rx_src[7] ? InOne : 8'h00;
          state_o.rx_shift      = {rx_src[6:0], 1'b0};
          state_o.rx_count      = rx_cnt[CntW-1:0];
          state_o.rx_pending    = (rx_cnt != (CntW+1)'(ByteBits));
        end
      end
      OpWrite: begin
        if (req_i.write_data[CsIdx]) begin
          state_o.rx_shift   = Preload;
          state_o.rx_count   = '0;
          state_o.rx_pending = 1'b1;
        end else if (req_i.write_data[SendIdx]) begin
          state_o.tx_count = tx_cnt[CntW-1:0];
          if (tx_cnt == (CntW+1)'(ByteBits)) begin
            rsp_o.latch_valid = 1'b1;
            rsp_o.latch_byte  = tx_next;
            state_o.tx_shift  = '0;
          end else begin
            state_o.tx_shift  = tx_next;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

/* rtl/core/bit_banged_spi_port.sv */
// bit_banged_spi_port: bit-banged spi port behind byte-wide bus registers
// uses bbspi_pkg, bbspi_req_if/bbspi_rsp_if and bbspi_step
//
//   channel  dir  carries
//   req_i    in   op, write_data, card_has_byte, card_byte
//   rsp_o    out  read_data, card_byte_taken, latch_valid, latch_byte
//
// one request per cycle sustained while rsp_o.ready holds; each request passes through
// the input register and then the response register on its way to its response.
// the shift state updates as a request moves from the input register to the response register.
// while the response is stalled, the input register holds one more request.
// reset clears shift state, counters and both valid flags.
module bit_banged_spi_port import bbspi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  bbspi_req_if.sink    req_i,
  bbspi_rsp_if.source  rsp_o
);

  logic   in_valid_q;
  req_t   in_req_q;
  logic   out_valid_q;
  rsp_t   out_rsp_q;
  state_t state_q, state_d;
  rsp_t   rsp_d;
  logic   advance;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;

  bbspi_step u_step (
    .state_i (state_q),
    .req_i   (in_req_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (req_i.ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_req_q <= req_i.payload;
    end
    if (advance) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_rsp_q;

  a_rx_count_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.rx_count != '0) |-> state_q.rx_pending)
    else $error("receive bit count without pending byte");

  a_latch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_rsp_q.latch_valid) |-> (out_rsp_q.latch_byte == 8'h00))
    else $error("latch byte set without latch valid");

  a_taken_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rsp_q.card_byte_taken) |-> !out_rsp_q.latch_valid)
    else $error("card byte taken on a write");

  a_read_data_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_rsp_q.read_data == 8'h00 || out_rsp_q.read_data == InOne))
    else $error("read data outside its two codes");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_req_q) && $stable(state_q)))
    else $error("stalled request or state changed");

endmodule

/* tb/bit_banged_spi_port_checker.sv */
// checker for bit_banged_spi_port: predicts each response from the accepted requests
// and compares it field by field; uses bbspi_pkg
module bit_banged_spi_port_checker import bbspi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_payload_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_payload_i,
  output int unsigned mismatches_o,
  output int unsigned awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]      tx_byte;
  logic [CntW-1:0] tx_bits;
  logic [7:0]      rx_byte;
  logic [CntW-1:0] rx_bits;
  logic            rx_busy;
  rsp_t            awaited_rsp[$];

  function automatic rsp_t port_response(input req_t r);
    rsp_t o;
    o = '0;
    if (r.op == OpRead) begin
      if (!rx_busy && r.card_has_byte) begin
        rx_byte = r.card_byte;
        rx_bits = '0;
        rx_busy = 1'b1;
        o.card_byte_taken = 1'b1;
      end
      if (rx_busy) begin
        o.read_data = rx_byte[7] ? InOne : 8'h00;
        rx_byte = rx_byte << 1;
        if (rx_bits == CntW'(ByteBits - 1)) begin
          rx_bits = '0;
          rx_busy = 1'b0;
        end else begin
          rx_bits = rx_bits + CntW'(1);
        end
      end
    end else if (r.write_data[CsIdx]) begin
      rx_byte = Preload;
      rx_bits = '0;
      rx_busy = 1'b1;
    end else if (r.write_data[SendIdx]) begin
      // data bit on the bus is inverted
      tx_byte = {tx_byte[6:0], ~r.write_data[DataIdx]};
      if (tx_bits == CntW'(ByteBits - 1)) begin
        o.latch_valid = 1'b1;
        o.latch_byte  = tx_byte;
        tx_byte = '0;
        tx_bits = '0;
      end else begin
        tx_bits = tx_bits + CntW'(1);
      end
    end
    return o;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", field, want, got);
      mismatches_o++;
    end
  endfunction

  // handshakes are sampled on the falling edge ahead of the rising edge that completes them
  always @(negedge clk_i) begin
    rsp_t want;
    if (!rst_ni) begin
      tx_byte = '0;
      tx_bits = '0;
      rx_byte = '0;
      rx_bits = '0;
      rx_busy = 1'b0;
      awaited_rsp.delete();
      mismatches_o = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          $error("response with no request outstanding");
          mismatches_o++;
        end else begin
          want = awaited_rsp.pop_front();
          check_field("read_data", want.read_data, rsp_payload_i.read_data);
          check_field("card_byte_taken", 8'(want.card_byte_taken),
                      8'(rsp_payload_i.card_byte_taken));
          check_field("latch_valid", 8'(want.latch_valid),
                      8'(rsp_payload_i.latch_valid));
          check_field("latch_byte", want.latch_byte, rsp_payload_i.latch_byte);
        end
      end
      if (req_valid_i && req_ready_i) begin
        awaited_rsp.push_back(port_response(req_payload_i));
      end
    end
    awaited_o = awaited_rsp.size();
  end

endmodule

/* tb/bit_banged_spi_port_test.sv */
// testbench top for bit_banged_spi_port: directed and random bus accesses with
// random stalls on both channels; uses bbspi_pkg, bbspi_if and the checker
module bit_banged_spi_port_test import bbspi_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned quiet_cycles = 0;

  bbspi_req_if req ();
  bbspi_rsp_if rsp ();

  bit_banged_spi_port dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  bit_banged_spi_port_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req.valid),
    .req_ready_i   (req.ready),
    .req_payload_i (req.payload),
    .rsp_valid_i   (rsp.valid),
    .rsp_ready_i   (rsp.ready),
    .rsp_payload_i (rsp.payload),
    .mismatches_o  (mismatches),
    .awaited_o     (awaited)
  );

  always #6ns clk_i = ~clk_i;

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic issue_access(input op_e op, input logic [7:0] wd, input logic has,
                              input logic [7:0] cb);
    req_t r;
    logic took;
    r.op            = op;
    r.write_data    = wd;
    r.card_has_byte = has;
    r.card_byte     = cb;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid   <= 1'b1;
    req.payload <= r;
    do begin
      @(negedge clk_i);
      took = req.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // mostly well-formed traffic: card reads, sent bits, chip selects, some raw writes
  task automatic random_access();
    logic [7:0] wd;
    int unsigned pick;
    wd   = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 45) begin
      issue_access(OpRead, wd, ($urandom_range(3) != 0), 8'($urandom));
    end else if (pick < 85) begin
      wd[CsIdx]   = 1'b0;
      wd[SendIdx] = 1'b1;
      issue_access(OpWrite, wd, 1'($urandom), 8'($urandom));
    end else if (pick < 93) begin
      wd[CsIdx] = 1'b1;
      issue_access(OpWrite, wd, 1'($urandom), 8'($urandom));
    end else begin
      issue_access(OpWrite, wd, 1'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    req.valid     = 1'b0;
    req.payload   = '0;
    rst_ni        = 1'b0;
    src_idle_pct  = 6;
    sink_idle_pct = 83;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle read, writes with no effect, chip select together with send
    issue_access(OpRead, 8'h00, 1'b0, 8'h00);
    issue_access(OpWrite, 8'h00, 1'b0, 8'hFF);
    issue_access(OpWrite, 8'hEB, 1'b1, 8'h00);
    issue_access(OpWrite, 8'hFF, 1'b1, 8'hFF);
    // preloaded byte shifts out, card byte offered but not taken
    for (int i = 0; i < 8; i++) begin
      issue_access(OpRead, 8'hFF, 1'b1, (i % 2 == 0) ? 8'hFF : 8'h00);
    end
    // take a card byte, then chip select replaces it mid-byte
    issue_access(OpRead, 8'h00, 1'b1, 8'h5A);
    issue_access(OpWrite, 8'h14, 1'b0, 8'h00);
    // eight sent bits complete a latched byte
    for (int i = 0; i < 8; i++) begin
      issue_access(OpWrite, (i % 3 == 0) ? 8'hFB : 8'h10, 1'b0, 8'h00);
    end
    issue_access(OpRead, 8'h00, 1'b1, 8'h00);
    issue_access(OpRead, 8'h00, 1'b0, 8'hA5);

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        src_idle_pct  = 83;
        sink_idle_pct = 6;
      end else if (p == 2) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      for (int i = 0; i < PhaseItems; i++) begin
        random_access();
      end
      // hold off until every response is back
      req.valid <= 1'b0;
      while (awaited != 0) @(posedge clk_i);
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bbspi_pkg.sv
rtl/core/bbspi_if.sv
rtl/core/bbspi_step.sv
rtl/core/bit_banged_spi_port.sv
tb/bit_banged_spi_port_checker.sv
tb/bit_banged_spi_port_test.sv
